// ===== hdl/stuffed_packet_deframer_crc16_top_defines.svh =====
// ----------------------------------------------------------------------------
// stuffed_packet_deframer_crc16_top_defines
// Assertion macros used by the deframer's checker file.
// ----------------------------------------------------------------------------
`ifndef STUFFED_PACKET_DEFRAMER_CRC16_TOP_DEFINES_SVH
`define STUFFED_PACKET_DEFRAMER_CRC16_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deframer check failed");

// Check that one condition implies another on the same edge.
`define SPD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    `SPD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== hdl/spd_crc16_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_crc16_pkg
// Types, symbols and the reflected CRC-16 (DNP polynomial) byte update for the stuffed deframer.
// ----------------------------------------------------------------------------
package spd_crc16_pkg;

    localparam logic [7:0]  SYM_START     = 8'hCA;
    localparam logic [7:0]  SYM_ESC       = 8'hC0;
    localparam logic [7:0]  ESC_OF_ESC    = 8'h00;
    localparam logic [7:0]  ESC_OF_START  = 8'h0A;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA6BC;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_ID      = 4'd1,
        ST_SUBID   = 4'd2,
        ST_LENGTH  = 4'd3,
        ST_PAYLOAD = 4'd4,
        ST_CRCLO   = 4'd5,
        ST_CRCHI   = 4'd6,
        ST_OK      = 4'd7,
        ST_FAIL    = 4'd8
    } t_parse_state;

    // Reflected CRC, one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/stuffed_packet_deframer_crc16_top.sv =====
// ----------------------------------------------------------------------------
// stuffed_packet_deframer_crc16_top
// Byte-stuffed frame parser with CRC-16 check (DNP polynomial, seed 0xFFFF).
//
// Takes one raw received byte per word on the input channel and returns one
// result word for each: the parser stage after that byte, the unstuffed
// payload byte when there is one (with a last-byte flag), and the stored id,
// sub-id and length of the current frame. 0xCA restarts a frame; 0xC0 0x00
// and 0xC0 0x0A stand for 0xC0 and 0xCA; any other escaped byte drops to
// idle. The CRC runs over the raw bytes from the start byte through the
// payload and is checked against the little-endian CRC that follows. One
// byte is accepted every cycle unless the result word stalls: the CRC update
// and stage decision are done in the cycle of acceptance and land in the
// result register, which the output may drain while the next byte comes in.
// ----------------------------------------------------------------------------
module stuffed_packet_deframer_crc16_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_raw_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_status,
    output logic       o_data_valid,
    output logic [7:0] o_data_byte,
    output logic       o_last_payload,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_frame_sub_id,
    output logic [7:0] o_frame_length
);
    import spd_crc16_pkg::*;

    t_parse_state r_state, n_state;
    logic         r_esc, n_esc;
    logic [15:0]  r_crc, n_crc;
    logic [7:0]   r_count, n_count;
    logic [7:0]   r_id, n_id;
    logic [7:0]   r_sub_id, n_sub_id;
    logic [7:0]   r_length, n_length;
    logic [7:0]   r_crc_low, n_crc_low;

    logic         r_out_valid;
    logic [3:0]   r_status;
    logic         r_data_valid;
    logic [7:0]   r_data_byte;
    logic         r_last;

    logic         w_accept;
    logic         w_proceed;
    logic [7:0]   w_byte;
    logic [7:0]   w_count_inc;
    logic         w_data_valid;
    logic         w_last;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_count_inc = r_count + 8'd1;

    // Next state: escape handling, CRC update and stage walk.
    always_comb begin
        n_state   = r_state;
        n_esc     = r_esc;
        n_crc     = r_crc;
        n_count   = r_count;
        n_id      = r_id;
        n_sub_id  = r_sub_id;
        n_length  = r_length;
        n_crc_low = r_crc_low;
        w_byte    = i_raw_byte;
        w_proceed = 1'b0;
        if (i_raw_byte == SYM_START) begin
            // restart; escape flag deliberately left alone
            n_crc   = crc_feed(CRC_SEED, SYM_START);
            n_state = ST_ID;
        end else begin
            if (r_state == ST_ID || r_state == ST_SUBID || r_state == ST_LENGTH ||
                r_state == ST_PAYLOAD) begin
                n_crc = crc_feed(r_crc, i_raw_byte);
            end
            if (r_esc) begin
                n_esc = 1'b0;
                if (i_raw_byte == ESC_OF_ESC || i_raw_byte == ESC_OF_START) begin
                    w_byte    = SYM_ESC | i_raw_byte;
                    w_proceed = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end else if (i_raw_byte == SYM_ESC) begin
                n_esc = 1'b1;
            end else begin
                w_proceed = 1'b1;
            end
            if (w_proceed) begin
                case (r_state)
                    ST_ID: begin
                        n_id    = w_byte;
                        n_state = ST_SUBID;
                    end
                    ST_SUBID: begin
                        n_sub_id = w_byte;
                        n_state  = ST_LENGTH;
                    end
                    ST_LENGTH: begin
                        n_count  = 8'd0;
                        n_length = w_byte;
                        n_state  = (w_byte == 8'd0) ? ST_CRCLO : ST_PAYLOAD;
                    end
                    ST_PAYLOAD: begin
                        n_count = w_count_inc;
                        if (w_count_inc == r_length) begin
                            n_state = ST_CRCLO;
                        end
                    end
                    ST_CRCLO: begin
                        n_crc_low = w_byte;
                        n_state   = ST_CRCHI;
                    end
                    ST_CRCHI: begin
                        n_crc   = r_crc ^ CRC_SEED;
                        n_state = ((r_crc ^ CRC_SEED) == {w_byte, r_crc_low}) ?
                                  ST_OK : ST_FAIL;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // Result flags for the accepted word.
    always_comb begin
        w_data_valid = w_proceed && (r_state == ST_PAYLOAD);
        w_last       = w_data_valid && (w_count_inc == r_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_esc       <= 1'b0;
            r_crc       <= CRC_SEED;
            r_count     <= 8'd0;
            r_id        <= 8'd0;
            r_sub_id    <= 8'd0;
            r_length    <= 8'd0;
            r_crc_low   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_esc       <= n_esc;
                r_crc       <= n_crc;
                r_count     <= n_count;
                r_id        <= n_id;
                r_sub_id    <= n_sub_id;
                r_length    <= n_length;
                r_crc_low   <= n_crc_low;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; hold while the output side stalls.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_state;
            r_data_valid <= w_data_valid;
            r_data_byte  <= w_data_valid ? w_byte : 8'd0;
            r_last       <= w_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_data_valid   = r_data_valid;
    assign o_data_byte    = r_data_byte;
    assign o_last_payload = r_last;
    assign o_frame_id     = r_id;
    assign o_frame_sub_id = r_sub_id;
    assign o_frame_length = r_length;

endmodule

// ===== hdl/spd_crc16_checker.sv =====
// ----------------------------------------------------------------------------
// spd_crc16_checker
// Port-level checks for the stuffed deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "stuffed_packet_deframer_crc16_top_defines.svh"

module spd_crc16_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_raw_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_status,
    input logic       o_data_valid,
    input logic [7:0] o_data_byte,
    input logic       o_last_payload,
    input logic [7:0] o_frame_id,
    input logic [7:0] o_frame_sub_id,
    input logic [7:0] o_frame_length
);
    import spd_crc16_pkg::*;

    // A stalled result word holds.
    `SPD_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, ##1 (o_out_valid && $stable(o_status) && $stable(o_data_byte)))

    // Payload bytes appear only while walking the payload or just leaving it.
    `SPD_ASSERT_IMPLY(a_data_stage, i_clk, i_rst_n, o_out_valid && o_data_valid, o_status == ST_PAYLOAD || o_status == ST_CRCLO)

    // The last payload byte moves the parser to the CRC, and nothing else does.
    `SPD_ASSERT_IMPLY(a_last_stage, i_clk, i_rst_n, o_out_valid && o_data_valid, o_last_payload == (o_status == ST_CRCLO))

    // Without a payload byte the data lane stays clear.
    `SPD_ASSERT_IMPLY(a_data_clear, i_clk, i_rst_n, o_out_valid && !o_data_valid, o_data_byte == 8'd0 && !o_last_payload)

endmodule

bind stuffed_packet_deframer_crc16_top spd_crc16_checker u_spd_crc16_checker (.*);

// ===== verif/tb_stuffed_packet_deframer_crc16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_packet_deframer_crc16_top
// Self-checking bench for the byte-stuffed frame deframer with CRC-16 (DNP polynomial).
//
// Raw bytes go in one word at a time with random gaps. Each byte accepted is
// run through a local parser model that tracks stage, escape, CRC and the
// stored header fields. The expected result words queue up in order. Each
// word the block returns is checked field by field against the oldest one.
// Frames are built with proper stuffing and CRC. The run covers good and bad
// CRCs, truncated frames, broken escapes and raw noise, with random stalls
// on the result side.
// ----------------------------------------------------------------------------
module tb_stuffed_packet_deframer_crc16_top;
    import spd_crc16_pkg::*;

    typedef struct {
        t_parse_state status;
        logic         dv;
        logic [7:0]   data;
        logic         last;
        logic [7:0]   id;
        logic [7:0]   sub_id;
        logic [7:0]   length;
    } t_deframe_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_raw_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_status;
    logic       o_data_valid;
    logic [7:0] o_data_byte;
    logic       o_last_payload;
    logic [7:0] o_frame_id;
    logic [7:0] o_frame_sub_id;
    logic [7:0] o_frame_length;

    // parser model state
    t_parse_state dp_state = ST_IDLE;
    logic         dp_esc = 1'b0;
    logic [15:0]  dp_crc = CRC_SEED;
    logic [7:0]   dp_count = 8'h00;
    logic [7:0]   dp_id = 8'h00;
    logic [7:0]   dp_sub_id = 8'h00;
    logic [7:0]   dp_length = 8'h00;
    logic [7:0]   dp_crc_low = 8'h00;

    t_deframe_word parsed_q[$];

    // frame under construction
    logic [7:0]  tx_frame[$];
    logic [15:0] frame_crc;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold = 0;

    int n_errors = 0;
    int n_sent = 0;
    int n_words_in = 0;
    int n_frames_ok = 0;
    int n_frames_bad = 0;
    int n_payload = 0;
    int n_bad_escapes = 0;

    stuffed_packet_deframer_crc16_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_raw_byte     (i_raw_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_data_valid   (o_data_valid),
        .o_data_byte    (o_data_byte),
        .o_last_payload (o_last_payload),
        .o_frame_id     (o_frame_id),
        .o_frame_sub_id (o_frame_sub_id),
        .o_frame_length (o_frame_length)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_stuffed_packet_deframer_crc16_top: done, errors");
        $finish;
    end

    // CRC-16 with the DNP polynomial, reflected, one bit at a time
    function automatic logic [15:0] crc_dnp_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) r = r ^ CRC_POLY_REFL;
        end
        return r;
    endfunction

    // Advance the parser model by one raw byte and queue the word it yields.
    function automatic void deframe_byte(input logic [7:0] raw);
        t_deframe_word w;
        logic [7:0]    b;
        logic          done;
        b      = raw;
        done   = 1'b0;
        w.dv   = 1'b0;
        w.data = 8'h00;
        w.last = 1'b0;
        if (raw == SYM_START) begin
            // restart; escape flag survives on purpose
            dp_crc   = crc_dnp_step(CRC_SEED, raw);
            dp_state = ST_ID;
            done     = 1'b1;
        end else begin
            if (dp_state >= ST_ID && dp_state <= ST_PAYLOAD)
                dp_crc = crc_dnp_step(dp_crc, raw);
            if (dp_esc) begin
                dp_esc = 1'b0;
                if (raw == ESC_OF_ESC || raw == ESC_OF_START) begin
                    b = SYM_ESC | raw;
                end else begin
                    dp_state = ST_IDLE;
                    done     = 1'b1;
                    n_bad_escapes++;
                end
            end else if (raw == SYM_ESC) begin
                dp_esc = 1'b1;
                done   = 1'b1;
            end
        end
        if (!done) begin
            case (dp_state)
                ST_ID: begin
                    dp_id    = b;
                    dp_state = ST_SUBID;
                end
                ST_SUBID: begin
                    dp_sub_id = b;
                    dp_state  = ST_LENGTH;
                end
                ST_LENGTH: begin
                    dp_count  = 8'h00;
                    dp_length = b;
                    dp_state  = (b == 8'h00) ? ST_CRCLO : ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    dp_count = dp_count + 8'd1;
                    w.dv     = 1'b1;
                    w.data   = b;
                    n_payload++;
                    if (dp_count == dp_length) begin
                        w.last   = 1'b1;
                        dp_state = ST_CRCLO;
                    end
                end
                ST_CRCLO: begin
                    dp_crc_low = b;
                    dp_state   = ST_CRCHI;
                end
                ST_CRCHI: begin
                    dp_crc = ~dp_crc;
                    if (dp_crc == {b, dp_crc_low}) begin
                        dp_state = ST_OK;
                        n_frames_ok++;
                    end else begin
                        dp_state = ST_FAIL;
                        n_frames_bad++;
                    end
                end
                default: begin
                    dp_state = ST_IDLE;
                end
            endcase
        end
        w.status = dp_state;
        w.id     = dp_id;
        w.sub_id = dp_sub_id;
        w.length = dp_length;
        parsed_q.push_back(w);
    endfunction

    function automatic void flag_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                         $realtime, name, want, got);
        end
    endfunction

    function automatic void check_word();
        t_deframe_word w;
        if (parsed_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] result word with nothing pending (status %0d)",
                         $realtime, o_status);
            return;
        end
        w = parsed_q.pop_front();
        n_words_in++;
        flag_field("status", 16'(w.status), 16'(o_status));
        flag_field("data_valid", 16'(w.dv), 16'(o_data_valid));
        flag_field("data_byte", 16'(w.data), 16'(o_data_byte));
        flag_field("last_payload", 16'(w.last), 16'(o_last_payload));
        flag_field("frame_id", 16'(w.id), 16'(o_frame_id));
        flag_field("frame_sub_id", 16'(w.sub_id), 16'(o_frame_sub_id));
        flag_field("frame_length", 16'(w.length), 16'(o_frame_length));
    endfunction

    // Check the word that moved at this edge, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_word();
            if (!rx_idle_on) begin
                i_out_ready <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:19]: begin
                        rx_hold = $urandom_range(0, 2);
                        i_out_ready <= 1'b0;
                    end
                    [20:22]: begin
                        rx_hold = $urandom_range(8, 40);
                        i_out_ready <= 1'b0;
                    end
                    default: i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!tx_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one raw byte, hold it until accepted, then maybe idle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_raw_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every pending word has come back.
    task automatic wait_parsed_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (parsed_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return SYM_START;
            1:       return SYM_ESC;
            2:       return ESC_OF_ESC;
            3:       return ESC_OF_START;
            4:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_raw(input logic [7:0] b, input logic feed);
        tx_frame.push_back(b);
        if (feed) frame_crc = crc_dnp_step(frame_crc, b);
    endfunction

    function automatic void put_stuffed(input logic [7:0] b, input logic feed);
        if (b == SYM_ESC || b == SYM_START) begin
            push_raw(SYM_ESC, feed);
            push_raw((b == SYM_ESC) ? ESC_OF_ESC : ESC_OF_START, feed);
        end else begin
            push_raw(b, feed);
        end
    endfunction

    function automatic void open_frame(input logic [7:0] id, input logic [7:0] sub_id,
                                       input logic [7:0] length);
        tx_frame.delete();
        frame_crc = CRC_SEED;
        push_raw(SYM_START, 1'b1);
        put_stuffed(id, 1'b1);
        put_stuffed(sub_id, 1'b1);
        put_stuffed(length, 1'b1);
    endfunction

    // Append the trailer, stuffed but outside the CRC; corrupt it if asked.
    function automatic void close_frame(input logic good);
        logic [15:0] fcs;
        fcs = ~frame_crc;
        if (!good) fcs = fcs ^ 16'($urandom_range(1, 65535));
        put_stuffed(fcs[7:0], 1'b0);
        put_stuffed(fcs[15:8], 1'b0);
    endfunction

    task automatic send_frame();
        foreach (tx_frame[k]) send_byte(tx_frame[k]);
    endtask

    function automatic void build_random_frame(input int length, input logic good);
        open_frame(pick_byte(), pick_byte(), 8'(length));
        repeat (length) put_stuffed(pick_byte(), 1'b1);
        close_frame(good);
    endfunction

    task automatic test_zero_length_frame();
        open_frame(8'h00, 8'hFF, 8'h00);
        close_frame(1'b1);
        send_frame();
        // a plain byte after success, then one more in idle
        send_byte(8'h55);
        send_byte(8'h55);
    endtask

    task automatic test_stuffed_fields_bad_crc();
        open_frame(SYM_START, SYM_ESC, 8'd3);
        put_stuffed(SYM_START, 1'b1);
        put_stuffed(8'h00, 1'b1);
        put_stuffed(8'hFF, 1'b1);
        close_frame(1'b0);
        send_frame();
        send_byte(8'hAA);
    endtask

    task automatic test_escape_corner_cases();
        // escape followed by a non-code byte in the payload
        send_byte(SYM_START);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h03);
        send_byte(SYM_ESC);
        send_byte(8'h55);
        // escape pair while idle
        send_byte(SYM_ESC);
        send_byte(ESC_OF_START);
        // start while escaped: next byte completes the pair as the id
        send_byte(SYM_ESC);
        send_byte(SYM_START);
        send_byte(ESC_OF_START);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h33);
    endtask

    task automatic test_max_length_frame();
        build_random_frame(255, 1'b1);
        send_frame();
        build_random_frame(1, 1'b0);
        send_frame();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (5) begin
            build_random_frame($urandom_range(0, 6), 1'b1);
            send_frame();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int  first;
        int  r;
        int  length;
        int  cut;
        bit  paused;
        first  = n_sent;
        paused = 1'b0;
        while (n_sent - first < n_bytes) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 19))
                0, 1:    length = 0;
                2:       length = $urandom_range(13, 40);
                default: length = $urandom_range(1, 12);
            endcase
            if (r < 70) begin
                build_random_frame(length, 1'b1);
            end else if (r < 80) begin
                build_random_frame(length, 1'b0);
            end else if (r < 88) begin
                // truncate: the next start byte restarts the parser
                build_random_frame(length, 1'b1);
                cut = $urandom_range(1, tx_frame.size() - 1);
                repeat (cut) void'(tx_frame.pop_back());
            end else if (r < 94) begin
                build_random_frame(length, 1'b1);
                cut = $urandom_range(1, tx_frame.size() - 1);
                tx_frame.insert(cut, 8'($urandom_range(0, 255)));
                tx_frame.insert(cut, SYM_ESC);
            end else begin
                tx_frame.delete();
                if ($urandom_range(0, 1)) begin
                    tx_frame.push_back(SYM_ESC);
                    tx_frame.push_back(SYM_START);
                end
                repeat ($urandom_range(1, 6)) tx_frame.push_back(pick_byte());
            end
            send_frame();
            if (!paused && n_sent - first >= n_bytes / 2) begin
                paused = 1'b1;
                wait_parsed_drained();
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length_frame();
        test_stuffed_fields_bad_crc();
        test_escape_corner_cases();
        test_max_length_frame();
        test_back_to_back();
        test_random_traffic(40);

        wait_parsed_drained();
        repeat (10) @(posedge i_clk);
        if (parsed_q.size() != 0) begin
            n_errors += parsed_q.size();
            $display("%0d result words never arrived", parsed_q.size());
        end

        $display("summary: %0d bytes sent, %0d result words checked, %0d payload bytes",
                 n_sent, n_words_in, n_payload);
        $display("summary: %0d frames passed CRC, %0d failed, %0d broken escapes, %0d errors",
                 n_frames_ok, n_frames_bad, n_bad_escapes, n_errors);
        if (n_errors == 0)
            $display("tb_stuffed_packet_deframer_crc16_top: done, clean");
        else
            $display("tb_stuffed_packet_deframer_crc16_top: done, errors");
        $finish;
    end

endmodule
